[rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and codes for the thread table scheduler: slot states, item
// kinds, scheduling modes, status codes and the table write command.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

	// Field widths
	localparam int KIND_W   = 2;
	localparam int PRIO_W   = 8;
	localparam int STAMP_W  = 32;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int TID_W    = 4;

	// Slot state codes
	typedef enum logic [1:0] {
		SLOT_FREE  = 2'd0,
		SLOT_RUN   = 2'd1,
		SLOT_YIELD = 2'd2
	} slot_st_t;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_YIELD  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SCHED  = 2'd2;

	// Scheduling modes
	localparam logic [MODE_W-1:0] MODE_RR    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PRIO  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STAMP = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_RUN  = 2'd2;

	localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

	// Write command into the slot table (address travels separately)
	typedef struct packed {
		logic               st_we;
		slot_st_t           st;
		logic               key_we;
		logic [PRIO_W-1:0]  prio;
		logic [STAMP_W-1:0] stamp;
	} tts_wr_t;

endpackage

`default_nettype wire

[rtl/tts_table.sv]
// ----------------------------------------------------------------------------
// tts_table
// Slot table: per-slot state in resettable flops, priority and creation
// stamp in memories. One write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_table #(
	parameter int NUM_SLOTS = 16,
	parameter int IW        = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [IW-1:0]                 rd_addr,
	output tts_pkg::slot_st_t             rd_st,
	output logic [tts_pkg::PRIO_W-1:0]    rd_prio,
	output logic [tts_pkg::STAMP_W-1:0]   rd_stamp,
	input  logic [IW-1:0]                 wr_addr,
	input  tts_pkg::tts_wr_t              wr
);
	import tts_pkg::*;

	slot_st_t           state_q [NUM_SLOTS];
	logic [PRIO_W-1:0]  prio_mem [NUM_SLOTS];
	logic [STAMP_W-1:0] stamp_mem [NUM_SLOTS];
	logic               key0_ok_q;
	logic               rd_zero_q;
	slot_st_t           rd_st_q;
	logic [PRIO_W-1:0]  rd_prio_q;
	logic [STAMP_W-1:0] rd_stamp_q;

	// Slot states: slot 0 runnable after reset, the rest free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				state_q[i] <= (i == 0) ? SLOT_RUN : SLOT_FREE;
			end
			key0_ok_q <= 1'b0;
			rd_zero_q <= 1'b0;
		end else begin
			if (wr.st_we) begin
				state_q[wr_addr] <= wr.st;
			end
			if (wr.key_we && (wr_addr == '0)) begin
				key0_ok_q <= 1'b1;
			end
			// slot 0 keys read as zero until its first create
			rd_zero_q <= (rd_addr == '0) && !key0_ok_q;
		end
	end

	// Key memories and registered read
	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			prio_mem[wr_addr]  <= wr.prio;
			stamp_mem[wr_addr] <= wr.stamp;
		end
		rd_st_q    <= state_q[rd_addr];
		rd_prio_q  <= prio_mem[rd_addr];
		rd_stamp_q <= stamp_mem[rd_addr];
	end

	assign rd_st    = rd_st_q;
	assign rd_prio  = rd_zero_q ? '0 : rd_prio_q;
	assign rd_stamp = rd_zero_q ? '0 : rd_stamp_q;

endmodule

`default_nettype wire

[rtl/thread_table_scheduler_core.sv]
// ----------------------------------------------------------------------------
// thread_table_scheduler_core
// Thread slot table with create, yield and schedule items; round robin,
// lowest priority or earliest creation scheduling.
// ----------------------------------------------------------------------------
// Each item is handled on its own: s_tready is high only while the sequencer
// is idle. Create and schedule walk the slot table one slot per cycle through
// a single read port and a single 32-bit key comparator. A full scan reads
// every slot in turn, then S_FIN hands the result to the output register once
// that register is free, and the sequencer returns to idle for the next item;
// yield first passes through S_PREP, which marks the current slot. Create and
// round robin stop at the first hit and finish sooner. Kind 3 and an unused
// mode skip the scan. A finished result sits in the output register while the
// next item can be taken.
`default_nettype none

module thread_table_scheduler_core #(
	parameter int NUM_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: sched_mode
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	// input items
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] new_priority
	input  logic [1:0] s_tuser,   // [1:0] kind
	// result items
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [3:0] thread_id, [7:4] zero
	output logic [1:0] m_tuser    // [1:0] status
);
	import tts_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int EW = (IW > TID_W) ? IW : TID_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_FIN
	} seq_t;

	seq_t                 seq_q;
	logic [MODE_W-1:0]    mode_q;
	logic [KIND_W-1:0]    kind_q;
	logic [PRIO_W-1:0]    prio_q;
	logic [IW-1:0]        cur_q;
	logic [STAMP_W-1:0]   stamp_q;
	logic [IW-1:0]        addr_q;
	logic [CW-1:0]        cnt_q;
	logic                 pv_s1;
	logic                 plast_s1;
	logic [IW-1:0]        pidx_s1;
	logic                 found_q;
	logic [IW-1:0]        best_q;
	logic [STAMP_W-1:0]   best_key_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [TID_W-1:0]     res_tid_q;
	logic                 m_tvalid_q;
	logic [STATUS_W-1:0]  m_status_q;
	logic [TID_W-1:0]     m_tid_q;

	slot_st_t             rd_st;
	logic [PRIO_W-1:0]    rd_prio;
	logic [STAMP_W-1:0]   rd_stamp;
	tts_wr_t              wr;
	logic [IW-1:0]        wr_addr;

	logic                 mode_ok;
	logic [IW-1:0]        cur_next;
	logic [IW-1:0]        scan_start;
	logic [STAMP_W-1:0]   key;
	logic                 better;
	logic                 found_nx;
	logic [IW-1:0]        best_nx;
	logic [EW-1:0]        pidx_ext;
	logic [EW-1:0]        cur_ext;
	logic [EW-1:0]        best_ext;

	assign cfg_ready = 1'b1;
	assign s_tready  = (seq_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{(8 - TID_W){1'b0}}, m_tid_q};
	assign m_tuser   = m_status_q;

	tts_table #(
		.NUM_SLOTS (NUM_SLOTS),
		.IW        (IW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (addr_q),
		.rd_st    (rd_st),
		.rd_prio  (rd_prio),
		.rd_stamp (rd_stamp),
		.wr_addr  (wr_addr),
		.wr       (wr)
	);

	// Scan helpers and the shared key comparator
	always_comb begin
		mode_ok    = (mode_q == MODE_RR) || (mode_q == MODE_PRIO) || (mode_q == MODE_STAMP);
		cur_next   = (cur_q == LAST_IDX) ? '0 : cur_q + 1'b1;
		scan_start = ((kind_q != KIND_CREATE) && (mode_q == MODE_RR)) ? cur_next : '0;
		key        = (mode_q == MODE_PRIO) ? {{(STAMP_W - PRIO_W){1'b0}}, rd_prio} : rd_stamp;
		better     = !found_q || (key < best_key_q);
		found_nx   = found_q;
		best_nx    = best_q;
		if (pv_s1 && (rd_st == SLOT_RUN) && better) begin
			found_nx = 1'b1;
			best_nx  = pidx_s1;
		end
		pidx_ext = EW'(pidx_s1);
		cur_ext  = EW'(cur_q);
		best_ext = EW'(best_nx);
	end

	// Table write command
	always_comb begin
		wr        = '0;
		wr.st     = SLOT_RUN;
		wr.prio   = prio_q;
		wr.stamp  = stamp_q;
		wr_addr   = pidx_s1;
		if (seq_q == S_PREP) begin
			wr.st_we = 1'b1;
			wr.st    = SLOT_YIELD;
			wr_addr  = cur_q;
		end else if ((seq_q == S_SCAN) && pv_s1) begin
			if (kind_q == KIND_CREATE) begin
				if (rd_st == SLOT_FREE) begin
					wr.st_we  = 1'b1;
					wr.key_we = 1'b1;
				end
			end else if (rd_st == SLOT_YIELD) begin
				// yielded slot met by the scan returns to runnable
				wr.st_we = 1'b1;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= S_IDLE;
			mode_q       <= MODE_RR;
			kind_q       <= KIND_CREATE;
			prio_q       <= '0;
			cur_q        <= '0;
			stamp_q      <= STAMP_W'(1);
			addr_q       <= '0;
			cnt_q        <= '0;
			pv_s1        <= 1'b0;
			plast_s1     <= 1'b0;
			pidx_s1      <= '0;
			found_q      <= 1'b0;
			best_q       <= '0;
			best_key_q   <= '0;
			res_status_q <= STATUS_OK;
			res_tid_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_status_q   <= STATUS_OK;
			m_tid_q      <= '0;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			// output register: load from S_FIN, clear on transfer
			if ((seq_q == S_FIN) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (seq_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q <= s_tuser;
						prio_q <= s_tdata;
						case (s_tuser)
							KIND_CREATE: begin
								addr_q  <= '0;
								cnt_q   <= '0;
								pv_s1   <= 1'b0;
								found_q <= 1'b0;
								seq_q   <= S_SCAN;
							end
							KIND_YIELD: begin
								seq_q <= S_PREP;
							end
							KIND_SCHED: begin
								if (mode_ok) begin
									addr_q  <= (mode_q == MODE_RR) ? cur_next : '0;
									cnt_q   <= '0;
									pv_s1   <= 1'b0;
									found_q <= 1'b0;
									seq_q   <= S_SCAN;
								end else begin
									res_status_q <= STATUS_NO_RUN;
									res_tid_q    <= '0;
									seq_q        <= S_FIN;
								end
							end
							default: begin
								res_status_q <= STATUS_OK;
								res_tid_q    <= cur_ext[TID_W-1:0];
								seq_q        <= S_FIN;
							end
						endcase
					end
				end

				// current slot is marked yielded this cycle
				S_PREP: begin
					if (mode_ok) begin
						addr_q  <= scan_start;
						cnt_q   <= '0;
						pv_s1   <= 1'b0;
						found_q <= 1'b0;
						seq_q   <= S_SCAN;
					end else begin
						res_status_q <= STATUS_NO_RUN;
						res_tid_q    <= '0;
						seq_q        <= S_FIN;
					end
				end

				S_SCAN: begin
					// issue side: one slot read per cycle
					if (cnt_q != CW'(NUM_SLOTS)) begin
						pv_s1    <= 1'b1;
						pidx_s1  <= addr_q;
						plast_s1 <= (cnt_q == CW'(NUM_SLOTS - 1));
						addr_q   <= (addr_q == LAST_IDX) ? '0 : addr_q + 1'b1;
						cnt_q    <= cnt_q + 1'b1;
					end else begin
						pv_s1 <= 1'b0;
					end

					// process side: data for the slot issued last cycle
					if (pv_s1) begin
						if (kind_q == KIND_CREATE) begin
							if (rd_st == SLOT_FREE) begin
								if (stamp_q != STAMP_MAX) begin
									stamp_q <= stamp_q + 1'b1;
								end
								res_status_q <= STATUS_OK;
								res_tid_q    <= pidx_ext[TID_W-1:0];
								seq_q        <= S_FIN;
							end else if (plast_s1) begin
								res_status_q <= STATUS_NO_FREE;
								res_tid_q    <= '0;
								seq_q        <= S_FIN;
							end
						end else if (mode_q == MODE_RR) begin
							if (rd_st == SLOT_RUN) begin
								cur_q        <= pidx_s1;
								res_status_q <= STATUS_OK;
								res_tid_q    <= pidx_ext[TID_W-1:0];
								seq_q        <= S_FIN;
							end else if (plast_s1) begin
								res_status_q <= STATUS_NO_RUN;
								res_tid_q    <= '0;
								seq_q        <= S_FIN;
							end
						end else begin
							if ((rd_st == SLOT_RUN) && better) begin
								found_q    <= 1'b1;
								best_q     <= pidx_s1;
								best_key_q <= key;
							end
							if (plast_s1) begin
								if (found_nx) begin
									cur_q        <= best_nx;
									res_status_q <= STATUS_OK;
									res_tid_q    <= best_ext[TID_W-1:0];
								end else begin
									res_status_q <= STATUS_NO_RUN;
									res_tid_q    <= '0;
								end
								seq_q <= S_FIN;
							end
						end
					end
				end

				// hand the result to the output register
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_status_q <= res_status_q;
						m_tid_q    <= res_tid_q;
						seq_q      <= S_IDLE;
					end
				end

				default: begin
					seq_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for thread_table_scheduler_core. A behavioral model
// of the slot table predicts the status and thread id for every accepted
// item. Each result transfer is checked against the oldest prediction. The
// stimulus is a directed part covering reset state, every item kind, every
// scheduling mode (the unused one included) and a full table, followed by
// random phases under several modes with random stalls, a long output
// hold-off and drain pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tts_pkg::*;

	localparam int SLOTS          = 16;
	localparam int DRAIN_CYCLES   = 30;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT    = 5000;

	// codes outside the documented ranges
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TID_W-1:0]    tid;
	} sched_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_data = '0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;   // [7:0] new_priority
	logic [1:0] s_tuser = '0;   // [1:0] kind
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;        // [3:0] thread_id, [7:4] zero
	logic [1:0] m_tuser;        // [1:0] status

	// model of the slot table
	slot_st_t           tbl_state [SLOTS];
	logic [PRIO_W-1:0]  tbl_prio  [SLOTS];
	logic [STAMP_W-1:0] tbl_stamp [SLOTS];
	logic [TID_W-1:0]   cur_slot;
	logic [STAMP_W-1:0] next_stamp;
	logic [MODE_W-1:0]  cur_mode;

	sched_result_t pending_results[$];
	int            err_count = 0;
	bit            tx_idle_on = 1'b0;
	bit            rx_idle_on = 1'b0;
	logic          rx_hold_start = 1'b0;
	int            rx_hold_left = 0;
	int            quiet_cycles = 0;

	thread_table_scheduler_core #(
		.NUM_SLOTS(SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one item to the table model and return its result
	function automatic sched_result_t apply_item(logic [KIND_W-1:0] kind,
			logic [PRIO_W-1:0] prio);
		sched_result_t      res;
		bit                 found;
		int                 pick;
		int                 idx;
		logic [STAMP_W-1:0] item_key;
		logic [STAMP_W-1:0] best_key;
		res = '0;
		found = 1'b0;
		pick = 0;
		best_key = '0;
		if (kind == KIND_CREATE) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && tbl_state[i] == SLOT_FREE) begin
					found = 1'b1;
					pick = i;
				end
			end
			if (found) begin
				tbl_state[pick] = SLOT_RUN;
				tbl_prio[pick] = prio;
				tbl_stamp[pick] = next_stamp;
				if (next_stamp != STAMP_MAX)
					next_stamp = next_stamp + 1;
				res.tid = pick[TID_W-1:0];
			end else begin
				res.status = STATUS_NO_FREE;
			end
		end else if (kind == KIND_YIELD || kind == KIND_SCHED) begin
			if (kind == KIND_YIELD)
				tbl_state[cur_slot] = SLOT_YIELD;
			if (cur_mode == MODE_RR) begin
				// first runnable after the current slot; yielded ones passed on the way wake up
				for (int i = 0; i < SLOTS; i++) begin
					idx = (int'(cur_slot) + 1 + i) % SLOTS;
					if (!found) begin
						if (tbl_state[idx] == SLOT_RUN) begin
							found = 1'b1;
							pick = idx;
						end else if (tbl_state[idx] == SLOT_YIELD) begin
							tbl_state[idx] = SLOT_RUN;
						end
					end
				end
			end else if (cur_mode != MODE_UNUSED) begin
				// smallest key among slots already runnable; first one wins on a tie
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_state[i] == SLOT_RUN) begin
						item_key = (cur_mode == MODE_PRIO) ? STAMP_W'(tbl_prio[i])
							: tbl_stamp[i];
						if (!found || item_key < best_key) begin
							found = 1'b1;
							pick = i;
							best_key = item_key;
						end
					end else if (tbl_state[i] == SLOT_YIELD) begin
						tbl_state[i] = SLOT_RUN;
					end
				end
			end
			if (found) begin
				cur_slot = pick[TID_W-1:0];
				res.tid = pick[TID_W-1:0];
			end else begin
				res.status = STATUS_NO_RUN;
			end
		end else begin
			res.tid = cur_slot;
		end
		return res;
	endfunction

	// Offer one item, wait for its transfer, then record the prediction
	task automatic send_item(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio);
		while (tx_idle_on && $urandom_range(0, 99) < 37) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= prio;
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_item(kind, prio));
	endtask

	// Stop offering and let every outstanding result come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mode register write; only called with the block idle
	task automatic write_mode(logic [MODE_W-1:0] mode);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mode = mode;
	endtask

	task automatic send_random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			send_item(KIND_CREATE, 8'($urandom));
		else if (r < 55)
			send_item(KIND_YIELD, 8'($urandom));
		else if (r < 92)
			send_item(KIND_SCHED, 8'($urandom));
		else
			send_item(KIND_NONE, 8'($urandom));
	endtask

	// Only slot 0 exists: schedule keeps it, yield finds nothing
	task automatic test_after_reset();
		send_item(KIND_SCHED, 8'h00);
		send_item(KIND_NONE, 8'hFF);
		send_item(KIND_YIELD, 8'h00);
		send_item(KIND_SCHED, 8'h00);
	endtask

	// Mode three never picks, but yield still marks the current slot
	task automatic test_unused_mode();
		wait_drained();
		write_mode(MODE_UNUSED);
		send_item(KIND_SCHED, 8'h00);
		send_item(KIND_YIELD, 8'h00);
		send_item(KIND_NONE, 8'h00);
		wait_drained();
		write_mode(MODE_RR);
		send_item(KIND_SCHED, 8'h00);
		send_item(KIND_SCHED, 8'h00);
	endtask

	// Fill every free slot, with priority ties and extremes, then overflow
	task automatic test_create_fill();
		send_item(KIND_CREATE, 8'hFF);
		send_item(KIND_CREATE, 8'h00);
		send_item(KIND_CREATE, 8'h00);
		send_item(KIND_CREATE, 8'hFF);
		for (int i = 0; i < SLOTS - 5; i++)
			send_item(KIND_CREATE, 8'($urandom));
		send_item(KIND_CREATE, 8'h5A);
	endtask

	// Yield and schedule once in each real mode
	task automatic test_each_mode();
		for (int m = 0; m < 3; m++) begin
			wait_drained();
			write_mode(MODE_W'(m));
			send_item(KIND_YIELD, 8'h00);
			send_item(KIND_SCHED, 8'h00);
		end
	endtask

	task automatic test_random_phase(logic [MODE_W-1:0] mode, int count, bit stalls);
		wait_drained();
		write_mode(mode);
		tx_idle_on = stalls;
		rx_idle_on = stalls;
		for (int i = 0; i < count; i++)
			send_random_item();
	endtask

	// Output held off while items keep coming, so the input backs up
	task automatic test_receiver_holdoff();
		tx_idle_on = 1'b0;
		rx_hold_start <= 1'b1;
		@(posedge clk);
		rx_hold_start <= 1'b0;
		for (int i = 0; i < 16; i++)
			send_random_item();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Result transfers against the oldest prediction
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d thread_id %0d",
					$time, m_tuser, m_tdata[3:0]);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, m_tuser);
					err_count++;
				end
				if (m_tdata != {4'b0, want.tid}) begin
					$display("%0t: thread_id mismatch: expected %0d, actual 0x%02h",
						$time, want.tid, m_tdata);
					err_count++;
				end
			end
		end
	end

	// Receiver: random stalls, or a counted hold-off on request
	always @(posedge clk) begin
		if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			m_tready <= 1'b0;
		end else if (rx_hold_start) begin
			rx_hold_left <= RX_HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !rx_idle_on || ($urandom_range(0, 99) >= 37);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		// table model after reset
		for (int i = 0; i < SLOTS; i++) begin
			tbl_state[i] = SLOT_FREE;
			tbl_prio[i] = '0;
			tbl_stamp[i] = '0;
		end
		tbl_state[0] = SLOT_RUN;
		cur_slot = '0;
		next_stamp = 1;
		cur_mode = MODE_RR;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_unused_mode();
		test_create_fill();
		test_each_mode();
		test_random_phase(MODE_RR, 110, 1'b1);
		test_receiver_holdoff();
		test_random_phase(MODE_PRIO, 110, 1'b1);
		test_random_phase(MODE_STAMP, 110, 1'b0);
		test_random_phase(MODE_UNUSED, 60, 1'b1);
		test_random_phase(MODE_RR, 110, 1'b1);
		test_random_phase(MODE_STAMP, 100, 1'b1);
		test_random_phase(MODE_PRIO, 100, 1'b1);
		wait_drained();

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
